// File: rtl/vmst_pkg.sv
// Package for the vertex model-to-screen transform block.
// Holds fixed-point constants, the sequencer state type and the saturation helper.
// No dependencies.
`default_nettype none
package vmst_pkg;

  localparam int WORK_W = 32;
  localparam int FRAC_BITS = 16;
  localparam int SLOTS = 48;
  localparam int SLOT_W = 6;
  localparam int PROD_W = 66;
  localparam int ACC_W = 52;
  localparam int DIV_BITS = WORK_W + FRAC_BITS;
  localparam int DIM_W = 15;

  localparam logic signed [WORK_W-1:0] FX_ONE = WORK_W'(1) << FRAC_BITS;
  localparam logic signed [WORK_W-1:0] SAT_MAX = {1'b0, {(WORK_W-1){1'b1}}};
  localparam logic signed [WORK_W-1:0] SAT_MIN = {1'b1, {(WORK_W-1){1'b0}}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_MAC_END,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_VP_X,
    ST_VP_Y,
    ST_VP_END,
    ST_DONE
  } state_t;

  function automatic logic signed [WORK_W-1:0] sat_work(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(SAT_MAX);
    lo = {{(PROD_W-WORK_W){1'b1}}, SAT_MIN};
    if (v > hi) return SAT_MAX;
    else if (v < lo) return SAT_MIN;
    else return v[WORK_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/vmst_if.sv
// Channel interfaces for the vertex transform: input items, results, register writes.
// Depends on vmst_pkg.
`default_nettype none
interface vmst_in_if;
  import vmst_pkg::*;
  logic valid;
  logic ready;
  logic operation;
  logic [SLOT_W-1:0] coef_index;
  logic signed [WORK_W-1:0] coef_value;
  logic signed [WORK_W-1:0] pos_x;
  logic signed [WORK_W-1:0] pos_y;
  logic signed [WORK_W-1:0] pos_z;
  modport source (output valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface vmst_out_if;
  import vmst_pkg::*;
  logic valid;
  logic ready;
  logic signed [WORK_W-1:0] screen_x;
  logic signed [WORK_W-1:0] screen_y;
  logic signed [WORK_W-1:0] depth;
  modport source (output valid, screen_x, screen_y, depth, input ready);
  modport sink (input valid, screen_x, screen_y, depth, output ready);
endinterface

interface vmst_cfg_if;
  import vmst_pkg::*;
  logic valid;
  logic ready;
  logic index;
  logic [DIM_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/vertex_model_to_screen_transform.sv
// Top level of the vertex model-to-screen transform; sequencer and shared MAC datapath.
// Depends on vmst_pkg, vmst_if, vmst_ram and vmst_div.
//
// A load item writes one Q16.16 coefficient into the 48-entry store; slots above 47 are
// dropped. A transform item runs model, view and projection 4x4 products through one
// shared 33x33 multiplier and accumulator (16 issues per matrix), then divides x, y, z by
// w with one radix-2 divider (skipped when w is zero), then maps to the viewport on the
// same multiplier. Input ready is low from acceptance of a transform until its result
// is loaded into the output register, which waits while that register is still full.
// The coefficient store reads as zero after reset.
`default_nettype none
module vertex_model_to_screen_transform (
  input wire logic   clk,
  input wire logic   rst,
  vmst_in_if.sink    in_ch,
  vmst_out_if.source out_ch,
  vmst_cfg_if.sink   cfg_ch
);
  import vmst_pkg::*;

  state_t state, state_next;

  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;

  logic [SLOTS-1:0] coef_vld;
  logic coef_vld_q;
  logic [WORK_W-1:0] ram_rdata;
  logic ram_we;
  logic [SLOT_W-1:0] raddr;

  logic [1:0] mat;
  logic [3:0] issue_cnt;
  logic issue_done;
  logic issuing;
  logic s1_vld;
  logic [3:0] s1_idx;
  logic s2_vld;
  logic [3:0] s2_idx;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] shifted;
  logic signed [WORK_W-1:0] vec [4];
  logic signed [WORK_W-1:0] res [4];

  logic signed [WORK_W:0] ma;
  logic signed [WORK_W:0] mb;
  logic signed [PROD_W-1:0] mult;
  logic prod_en;

  logic [1:0] div_sel;
  logic div_start;
  logic div_busy;
  logic div_done;
  logic signed [WORK_W-1:0] div_q;

  logic signed [WORK_W-1:0] sx;
  logic signed [WORK_W-1:0] sy;
  logic out_load;
  logic in_acc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign ram_we = in_acc && (in_ch.operation == OP_LOAD) && (in_ch.coef_index < SLOT_W'(SLOTS));
  assign issuing = (state == ST_MAC) && !issue_done;
  assign raddr = {mat, issue_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= DIM_W'(640);
      screen_height <= DIM_W'(480);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_WIDTH:  screen_width <= cfg_ch.data;
        CFG_HEIGHT: screen_height <= cfg_ch.data;
      endcase
    end
  end

  vmst_ram #(.WIDTH(WORK_W), .DEPTH(SLOTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.coef_index),
    .wdata (in_ch.coef_value),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) coef_vld <= '0;
    else if (ram_we) coef_vld[in_ch.coef_index] <= 1'b1;
  end

  // Shared multiplier: matrix MAC or viewport scaling
  always_comb begin
    ma = {ram_rdata[WORK_W-1], ram_rdata};
    if (!coef_vld_q) ma = '0;
    mb = {vec[s1_idx[1:0]][WORK_W-1], vec[s1_idx[1:0]]};
    if (state == ST_VP_X) begin
      ma = {vec[0][WORK_W-1], vec[0]} + {FX_ONE[WORK_W-1], FX_ONE};
      mb = {{(WORK_W+1-DIM_W){1'b0}}, screen_width};
    end else if (state == ST_VP_Y) begin
      ma = {FX_ONE[WORK_W-1], FX_ONE} - {vec[1][WORK_W-1], vec[1]};
      mb = {{(WORK_W+1-DIM_W){1'b0}}, screen_height};
    end
  end
  assign mult = PROD_W'(ma) * PROD_W'(mb);
  assign prod_en = s1_vld || (state == ST_VP_X) || (state == ST_VP_Y);

  assign shifted = ACC_W'(s2_prod >>> FRAC_BITS);
  assign acc_sum = ((s2_idx[1:0] == 2'd0) ? ACC_W'(0) : acc) + shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= issuing;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    coef_vld_q <= coef_vld[raddr];
    s1_idx <= issue_cnt;
    s2_idx <= s1_idx;
    if (prod_en) s2_prod <= mult;
    if (s2_vld) begin
      acc <= acc_sum;
      if (s2_idx[1:0] == 2'd3) res[s2_idx[3:2]] <= sat_work(PROD_W'(acc_sum));
    end
    if (state == ST_VP_Y) sx <= sat_work(s2_prod >>> 1);
    if (state == ST_VP_END) sy <= sat_work(s2_prod >>> 1);
  end

  // Sequencer counters and vector register
  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= '0;
      issue_cnt <= '0;
      issue_done <= 1'b0;
      div_sel <= '0;
    end else begin
      if (in_acc) begin
        mat <= '0;
        issue_cnt <= '0;
        issue_done <= 1'b0;
      end else if (issuing) begin
        issue_cnt <= issue_cnt + 1'b1;
        if (issue_cnt == 4'd15) issue_done <= 1'b1;
      end else if (state == ST_MAC_END) begin
        mat <= mat + 1'b1;
        issue_done <= 1'b0;
        div_sel <= '0;
      end else if (state == ST_DIV_WAIT && div_done) begin
        div_sel <= div_sel + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      vec[0] <= in_ch.pos_x;
      vec[1] <= in_ch.pos_y;
      vec[2] <= in_ch.pos_z;
      vec[3] <= FX_ONE;
    end else if (state == ST_MAC_END) begin
      for (int i = 0; i < 4; i++) vec[i] <= res[i];
    end else if (state == ST_DIV_WAIT && div_done) begin
      vec[div_sel] <= div_q;
    end
  end

  assign div_start = (state == ST_DIV_START);

  vmst_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (vec[div_sel]),
    .den   (vec[3]),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && in_ch.operation == OP_XFORM) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (s2_vld && s2_idx == 4'd15) state_next = ST_MAC_END;
      end
      ST_MAC_END: begin
        if (mat != 2'd2) state_next = ST_MAC;
        else if (res[3] == '0) state_next = ST_VP_X;
        else state_next = ST_DIV_START;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_next = (div_sel == 2'd2) ? ST_VP_X : ST_DIV_START;
      end
      ST_VP_X:   state_next = ST_VP_Y;
      ST_VP_Y:   state_next = ST_VP_END;
      ST_VP_END: state_next = ST_DONE;
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_ch.valid || out_ch.ready) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (out_load) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.screen_x <= sx;
      out_ch.screen_y <= sy;
      out_ch.depth <= vec[2];
    end
  end

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_pipe_drained: assert property (@(posedge clk) disable iff (rst)
    s2_vld |-> state == ST_MAC) else $error("MAC pipeline active outside MAC state");
  a_xform_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.operation == OP_XFORM) |=> (state == ST_MAC && issue_cnt == 4'd0
      && mat == 2'd0)) else $error("transform did not start at first coefficient");
endmodule
`default_nettype wire

// File: rtl/vmst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module vmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/vmst_div.sv
// Restoring radix-2 signed fixed-point divider: (num << FRAC_BITS) / den, saturated.
// One quotient bit per cycle. Depends on vmst_pkg.
`default_nettype none
module vmst_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [vmst_pkg::WORK_W-1:0] num,
  input  wire logic signed [vmst_pkg::WORK_W-1:0] den,
  output logic                               busy,
  output logic                               done,
  output logic signed [vmst_pkg::WORK_W-1:0] quot
);
  import vmst_pkg::*;

  localparam int CNT_W = $clog2(DIV_BITS);

  logic [CNT_W-1:0] cnt;
  logic [DIV_BITS-1:0] dividend;
  logic [DIV_BITS-1:0] q;
  logic [WORK_W-1:0] rem;
  logic [WORK_W-1:0] dmag;
  logic neg;
  logic [WORK_W:0] rem_sh;
  logic [WORK_W:0] rem_sub;
  logic ge;
  logic [WORK_W-1:0] num_mag;
  logic [WORK_W-1:0] den_mag;

  assign num_mag = num[WORK_W-1] ? WORK_W'(-num) : WORK_W'(num);
  assign den_mag = den[WORK_W-1] ? WORK_W'(-den) : WORK_W'(den);
  assign rem_sh = {rem, dividend[DIV_BITS-1]};
  assign ge = rem_sh >= {1'b0, dmag};
  assign rem_sub = rem_sh - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {num_mag, {FRAC_BITS{1'b0}}};
      dmag <= den_mag;
      neg <= num[WORK_W-1] ^ den[WORK_W-1];
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      dividend <= {dividend[DIV_BITS-2:0], 1'b0};
      rem <= ge ? rem_sub[WORK_W-1:0] : rem_sh[WORK_W-1:0];
      q <= {q[DIV_BITS-2:0], ge};
    end
  end

  // Saturate magnitude, then apply sign
  always_comb begin
    if (!neg) begin
      quot = (q > DIV_BITS'(SAT_MAX)) ? SAT_MAX : q[WORK_W-1:0];
    end else begin
      quot = (q > {{(DIV_BITS-WORK_W){1'b0}}, SAT_MIN}) ? SAT_MIN : -q[WORK_W-1:0];
    end
  end
endmodule
`default_nettype wire

// File: dv/vertex_model_to_screen_transform_tb.sv
// Testbench for the vertex model-to-screen transform: directed table, then random phases.
// Results are checked against a behavioral fixed-point projection model kept in this file.
// Depends on vmst_pkg, vmst_if and the vertex_model_to_screen_transform RTL.
module vertex_model_to_screen_transform_tb;
  import vmst_pkg::*;

  typedef struct {
    logic signed [WORK_W-1:0] sx;
    logic signed [WORK_W-1:0] sy;
    logic signed [WORK_W-1:0] dz;
  } screen_pt_t;

  typedef struct {
    logic op;
    logic [SLOT_W-1:0] idx;
    logic signed [WORK_W-1:0] val;
    logic signed [WORK_W-1:0] x;
    logic signed [WORK_W-1:0] y;
    logic signed [WORK_W-1:0] z;
    bit typed;
    screen_pt_t pt;
  } vec_row_t;

  localparam longint ONE = 65536;
  localparam longint HI32 = 64'sd2147483647;
  localparam longint LO32 = -64'sd2147483648;
  localparam int LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycles = 0;
  int errors = 0;
  int src_idle = 28;
  int dst_idle = 67;
  int hold_req = 0;
  int hold_cnt = 0;

  longint coefs [SLOTS];
  longint vp_width;
  longint vp_height;
  screen_pt_t pts_q[$];

  vmst_in_if in_ch();
  vmst_out_if out_ch();
  vmst_cfg_if cfg_ch();

  vertex_model_to_screen_transform i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint sat32(longint v);
    if (v > HI32) return HI32;
    if (v < LO32) return LO32;
    return v;
  endfunction

  function automatic longint fx_quot(longint num, longint den);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint qs;
    n = longint'(num < 0 ? -num : num) << FRAC_BITS;
    d = longint'(den < 0 ? -den : den);
    q = n / d;
    if (q > (64'd1 << 62)) q = 64'd1 << 62;
    qs = longint'(q);
    if ((num < 0) != (den < 0)) qs = -qs;
    return sat32(qs);
  endfunction

  function automatic screen_pt_t project_vertex(longint px, longint py, longint pz);
    longint v [4];
    longint r [4];
    longint acc;
    longint nx, ny, nz;
    screen_pt_t pt;
    v[0] = px; v[1] = py; v[2] = pz; v[3] = ONE;
    for (int m = 0; m < 3; m++) begin
      for (int row = 0; row < 4; row++) begin
        acc = 0;
        for (int col = 0; col < 4; col++)
          acc += (coefs[m*16 + row*4 + col] * v[col]) >>> FRAC_BITS;
        r[row] = sat32(acc);
      end
      v = r;
    end
    if (v[3] == 0) begin
      nx = v[0]; ny = v[1]; nz = v[2];
    end else begin
      nx = fx_quot(v[0], v[3]);
      ny = fx_quot(v[1], v[3]);
      nz = fx_quot(v[2], v[3]);
    end
    pt.sx = WORK_W'(sat32(((nx + ONE) * vp_width) >>> 1));
    pt.sy = WORK_W'(sat32(((ONE - ny) * vp_height) >>> 1));
    pt.dz = WORK_W'(nz);
    return pt;
  endfunction

  task automatic send_item(vec_row_t r);
    in_ch.valid <= 1'b1;
    in_ch.operation <= r.op;
    in_ch.coef_index <= r.idx;
    in_ch.coef_value <= r.val;
    in_ch.pos_x <= r.x;
    in_ch.pos_y <= r.y;
    in_ch.pos_z <= r.z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (r.op == OP_LOAD) begin
      if (r.idx < SLOTS) coefs[r.idx] = longint'(r.val);
    end else if (r.typed) begin
      pts_q.push_back(r.pt);
    end else begin
      pts_q.push_back(project_vertex(r.x, r.y, r.z));
    end
    // random gap between transactions
    if ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic index, logic [DIM_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (index == CFG_WIDTH) vp_width = data;
    else vp_height = data;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pts_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic signed [WORK_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 0;
      2, 3: return FX_ONE;
      default: return $signed($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic logic signed [WORK_W-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return SAT_MAX;
      2: return SAT_MIN;
      default: return $signed($urandom_range(0, 1048575)) - 524288;
    endcase
  endfunction

  function automatic vec_row_t rand_row(logic op, logic [SLOT_W-1:0] idx);
    vec_row_t r;
    r.op = op;
    r.idx = idx;
    r.val = (op == OP_LOAD) ? rand_coef() : $urandom();
    r.x = (op == OP_XFORM) ? rand_pos() : $urandom();
    r.y = (op == OP_XFORM) ? rand_pos() : $urandom();
    r.z = (op == OP_XFORM) ? rand_pos() : $urandom();
    r.typed = 1'b0;
    return r;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_cnt <= hold_req;
      hold_req <= 0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= dst_idle);
    end
  end

  always @(posedge clk) begin
    screen_pt_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pts_q.size() == 0) begin
        $display("%0t: result with nothing expected: %h %h %h", $time,
                 out_ch.screen_x, out_ch.screen_y, out_ch.depth);
        errors++;
      end else begin
        e = pts_q.pop_front();
        if (out_ch.screen_x !== e.sx) begin
          $display("%0t: screen_x exp %h got %h", $time, e.sx, out_ch.screen_x);
          errors++;
        end
        if (out_ch.screen_y !== e.sy) begin
          $display("%0t: screen_y exp %h got %h", $time, e.sy, out_ch.screen_y);
          errors++;
        end
        if (out_ch.depth !== e.dz) begin
          $display("%0t: depth exp %h got %h", $time, e.dz, out_ch.depth);
          errors++;
        end
      end
    end
  end

  initial begin
    vec_row_t dir_tbl[$];
    vec_row_t r;
    screen_pt_t rst_pt;
    int sent;
    logic [DIM_W-1:0] widths [4];
    logic [DIM_W-1:0] heights [4];

    in_ch.valid = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_WIDTH;
    cfg_ch.data = '0;
    foreach (coefs[i]) coefs[i] = 0;
    vp_width = 640;
    vp_height = 480;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero store, w of zero: x, y, z pass through as zero
    rst_pt.sx = 32'sd20971520;
    rst_pt.sy = 32'sd15728640;
    rst_pt.dz = 0;
    r = rand_row(OP_XFORM, 0); r.typed = 1'b1; r.pt = rst_pt; dir_tbl.push_back(r);
    r = rand_row(OP_XFORM, 0); r.x = SAT_MAX; r.y = SAT_MIN; r.z = SAT_MAX;
    r.typed = 1'b1; r.pt = rst_pt; dir_tbl.push_back(r);
    // out-of-range slots are dropped
    r = rand_row(OP_LOAD, 6'd63); r.val = FX_ONE; dir_tbl.push_back(r);
    r = rand_row(OP_LOAD, 6'd48); r.val = SAT_MAX; dir_tbl.push_back(r);
    r = rand_row(OP_XFORM, 0); r.typed = 1'b1; r.pt = rst_pt; dir_tbl.push_back(r);
    // w = 1 through all three matrices, everything else zero
    r = rand_row(OP_LOAD, 6'd15); r.val = FX_ONE; dir_tbl.push_back(r);
    r = rand_row(OP_LOAD, 6'd31); r.val = FX_ONE; dir_tbl.push_back(r);
    r = rand_row(OP_LOAD, 6'd47); r.val = FX_ONE; dir_tbl.push_back(r);
    r = rand_row(OP_XFORM, 0); r.typed = 1'b1; r.pt = rst_pt; dir_tbl.push_back(r);
    // extreme coefficients drive the row sums into saturation
    r = rand_row(OP_LOAD, 6'd0); r.val = SAT_MAX; dir_tbl.push_back(r);
    r = rand_row(OP_LOAD, 6'd16); r.val = SAT_MAX; dir_tbl.push_back(r);
    r = rand_row(OP_LOAD, 6'd32); r.val = SAT_MIN; dir_tbl.push_back(r);
    r = rand_row(OP_XFORM, 0); r.x = SAT_MAX; dir_tbl.push_back(r);
    r = rand_row(OP_XFORM, 0); r.x = SAT_MIN; r.y = SAT_MIN; dir_tbl.push_back(r);
    r = rand_row(OP_LOAD, 6'd21); r.val = SAT_MIN; dir_tbl.push_back(r);
    r = rand_row(OP_LOAD, 6'd37); r.val = FX_ONE; dir_tbl.push_back(r);
    r = rand_row(OP_XFORM, 0); r.x = FX_ONE; r.y = SAT_MAX; dir_tbl.push_back(r);
    // negative w: quotients change sign
    r = rand_row(OP_LOAD, 6'd47); r.val = -FX_ONE; dir_tbl.push_back(r);
    r = rand_row(OP_XFORM, 0); r.x = -FX_ONE; r.y = FX_ONE; dir_tbl.push_back(r);
    r = rand_row(OP_XFORM, 0); r.x = 0; r.y = 0; r.z = 0; dir_tbl.push_back(r);
    foreach (dir_tbl[i]) send_item(dir_tbl[i]);
    drain();

    widths = '{15'd1, 15'd16384, 15'd32767, 15'd640};
    heights = '{15'd1, 15'd16384, 15'd0, 15'd480};
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 0) begin src_idle = 28; dst_idle = 67; end
      else if (ph == 1) begin src_idle = 67; dst_idle = 28; end
      else begin src_idle = 0; dst_idle = 0; end
      write_reg(CFG_WIDTH, widths[ph]);
      write_reg(CFG_HEIGHT, heights[ph]);
      if (ph == 2) hold_req <= 3000;
      sent = 0;
      while (sent < 225) begin
        if ($urandom_range(0, 3) != 0) begin
          // well-formed: load randomly chosen slots of the matrix set in order, then a few vertices
          for (int s = 0; s < SLOTS; s++) begin
            if ($urandom_range(0, 3) == 0) begin
              send_item(rand_row(OP_LOAD, s[SLOT_W-1:0]));
              sent++;
            end
          end
          repeat ($urandom_range(2, 8)) begin
            send_item(rand_row(OP_XFORM, SLOT_W'($urandom())));
            sent++;
          end
        end else begin
          // noise: loads and transforms mixed, loads anywhere, including dropped slots
          repeat ($urandom_range(1, 5)) begin
            send_item(rand_row(1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 63))));
            sent++;
          end
        end
      end
      drain();
    end

    if (errors == 0 && pts_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
